// File: rtl/tgac_pkg.sv
// Shared types, constants and glyph tables for the text glyph address cursor.
// Used by tgac_glyph_calc and text_glyph_address_cursor; no dependencies.
package tgac_pkg;

  typedef enum logic [2:0] {
    KIND_A12 = 3'd0,
    KIND_A16 = 3'd1,
    KIND_A24 = 3'd2,
    KIND_H16 = 3'd3,
    KIND_H24 = 3'd4
  } glyph_kind_t;

  localparam logic [1:0] FONT_SEL_12 = 2'd0;
  localparam logic [1:0] FONT_SEL_16 = 2'd1;
  localparam logic [1:0] FONT_SEL_24 = 2'd2;
  localparam logic [1:0] FONT_SEL_NONE = 2'd3;

  localparam logic [1:0] REG_FONT_SIZE = 2'd0;
  localparam logic [1:0] REG_START_X = 2'd1;
  localparam logic [1:0] REG_START_Y = 2'd2;

  localparam logic [7:0] CODE_BIAS = 8'hA0;
  localparam logic signed [15:0] CODE_FIRST = 16'sd161;
  localparam logic signed [15:0] ROW_CODES = 16'sd94;
  localparam logic signed [15:0] H24_ROW_SKIP = 16'sd15;

  localparam logic [19:0] BASE_A12 = 20'd0;
  localparam logic [19:0] BASE_A16 = BASE_A12 + 20'd1536;
  localparam logic [19:0] BASE_A24 = BASE_A16 + 20'd4096;
  localparam logic [19:0] BASE_H16 = BASE_A24 + 20'd12288;
  localparam logic [19:0] BASE_H24 = BASE_H16 + 20'd267616;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       restart;
  } tgac_item_t;

  typedef struct packed {
    logic [7:0] cursor_x;
    logic [8:0] cursor_y;
    logic [7:0] lead_byte;
    logic       lead_pending;
  } tgac_state_t;

  typedef struct packed {
    logic [1:0] font_size_sel;
    logic [7:0] start_x;
    logic [8:0] start_y;
  } tgac_cfg_t;

  typedef struct packed {
    logic [19:0] glyph_address;
    logic [6:0]  glyph_bytes;
    logic [7:0]  draw_x;
    logic [8:0]  draw_y;
    glyph_kind_t glyph_kind;
    logic        glyph_error;
  } tgac_result_t;

  function automatic logic [19:0] kind_base(glyph_kind_t k);
    logic [19:0] v;
    unique case (k)
      KIND_A12: v = BASE_A12;
      KIND_A16: v = BASE_A16;
      KIND_A24: v = BASE_A24;
      KIND_H16: v = BASE_H16;
      KIND_H24: v = BASE_H24;
      default:  v = BASE_A12;
    endcase
    return v;
  endfunction

  function automatic logic [6:0] kind_len(glyph_kind_t k);
    logic [6:0] v;
    unique case (k)
      KIND_A12: v = 7'd12;
      KIND_A16: v = 7'd16;
      KIND_A24: v = 7'd48;
      KIND_H16: v = 7'd32;
      KIND_H24: v = 7'd72;
      default:  v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] kind_w(glyph_kind_t k);
    logic [4:0] v;
    unique case (k)
      KIND_A12: v = 5'd8;
      KIND_A16: v = 5'd8;
      KIND_A24: v = 5'd16;
      KIND_H16: v = 5'd16;
      KIND_H24: v = 5'd24;
      default:  v = 5'd0;
    endcase
    return v;
  endfunction

  function automatic logic [4:0] kind_h(glyph_kind_t k);
    logic [4:0] v;
    unique case (k)
      KIND_A12: v = 5'd12;
      KIND_A16: v = 5'd16;
      KIND_A24: v = 5'd24;
      KIND_H16: v = 5'd16;
      KIND_H24: v = 5'd24;
      default:  v = 5'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/tgac_glyph_calc.sv
// Combinational glyph decode, font address calculation and cursor advance.
// Depends on tgac_pkg for the item, state, config and result types.
module tgac_glyph_calc import tgac_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = 240,
  parameter int unsigned SCREEN_HEIGHT = 320,
  parameter int unsigned GLYPH_GAP = 1
) (
  input  tgac_item_t   item_i,
  input  tgac_state_t  state_i,
  input  tgac_cfg_t    cfg_i,
  output tgac_state_t  state_o,
  output logic         has_result_o,
  output tgac_result_t result_o
);

  always_comb begin
    tgac_state_t       st;
    logic              hz;
    logic              nog;
    logic              neg;
    logic              err;
    logic signed [15:0] row_s;
    logic signed [15:0] col_s;
    logic signed [15:0] idx_s;
    logic [13:0]       idx_u;
    glyph_kind_t       kind;
    logic [4:0]        adv_w;
    logic [4:0]        adv_h;
    logic [9:0]        nx;
    logic [9:0]        ny;

    st = state_i;
    if (item_i.restart) begin
      st.cursor_x = cfg_i.start_x;
      st.cursor_y = cfg_i.start_y;
      st.lead_pending = 1'b0;
      st.lead_byte = 8'd0;
    end

    hz = st.lead_pending;
    nog = (cfg_i.font_size_sel == FONT_SEL_NONE) || (hz && (cfg_i.font_size_sel == FONT_SEL_12));

    row_s = $signed({8'd0, st.lead_byte}) - CODE_FIRST;
    if (cfg_i.font_size_sel == FONT_SEL_24) begin
      row_s = row_s - H24_ROW_SKIP;
    end
    col_s = $signed({8'd0, item_i.text_byte}) - CODE_FIRST;
    idx_s = row_s * ROW_CODES + col_s;
    neg = idx_s[15];

    if (nog) begin
      kind = KIND_A12;
    end else if (hz) begin
      kind = (cfg_i.font_size_sel == FONT_SEL_24) ? KIND_H24 : KIND_H16;
    end else begin
      kind = glyph_kind_t'({1'b0, cfg_i.font_size_sel});
    end
    err = nog || (hz && neg);
    idx_u = hz ? idx_s[13:0] : {6'd0, item_i.text_byte};

    adv_w = nog ? 5'd0 : kind_w(kind);
    adv_h = nog ? 5'd0 : kind_h(kind);

    state_o = st;
    has_result_o = 1'b0;
    result_o.draw_x = st.cursor_x;
    result_o.draw_y = st.cursor_y;
    result_o.glyph_kind = kind;
    result_o.glyph_error = err;
    result_o.glyph_bytes = err ? 7'd0 : kind_len(kind);
    result_o.glyph_address = err ? 20'd0 :
                             kind_base(kind) + 20'(idx_u) * 20'(kind_len(kind));

    nx = 10'(st.cursor_x) + 10'(adv_w) + 10'(GLYPH_GAP);
    ny = 10'(st.cursor_y);
    if (nx >= 10'(SCREEN_WIDTH)) begin
      nx = 10'd0;
      ny = 10'(st.cursor_y) + 10'(adv_h) + 10'(GLYPH_GAP);
      if (ny >= 10'(SCREEN_HEIGHT)) begin
        ny = 10'd0;
      end
    end

    if (item_i.text_byte == 8'd0) begin
      state_o.lead_pending = 1'b0;
    end else if (!st.lead_pending && (item_i.text_byte > CODE_BIAS)) begin
      state_o.lead_byte = item_i.text_byte;
      state_o.lead_pending = 1'b1;
    end else begin
      has_result_o = 1'b1;
      state_o.lead_pending = 1'b0;
      state_o.cursor_x = nx[7:0];
      state_o.cursor_y = ny[8:0];
    end
  end

endmodule

// File: rtl/text_glyph_address_cursor.sv
// Top level of the text glyph address cursor: configuration registers,
// input word register, cursor state and output word register.
// Depends on tgac_pkg and tgac_glyph_calc.
//
// Text bytes enter on the in_ channel (valid/ready); each accepted word is
// held in an input register, decoded combinationally against the cursor state and,
// if it completes a glyph, written to the output register that drives the out_
// channel once that register is empty or being read.
// One word is taken per cycle while in_ready is high; lead bytes and end-of-string bytes
// are consumed without producing an output word.
// While the receiver holds out_ready low, a word that makes no output still moves on,
// and a word that makes output waits in the input register while the output register
// is full; in_ready drops only when both registers are full and the output is stalled.
// Font size and cursor start position are written through the APB port at byte addresses
// 0, 4 and 8; the user must write them only while the block is idle, which is not enforced.
// Synchronous reset clears both valid flags, the cursor and the held lead
// byte, and sets the font size to 16 pixels.
module text_glyph_address_cursor import tgac_pkg::*; #(
  parameter int unsigned SCREEN_WIDTH = 240,
  parameter int unsigned SCREEN_HEIGHT = 320,
  parameter int unsigned GLYPH_GAP = 1
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [19:0] out_glyph_address,
  output logic [6:0]  out_glyph_bytes,
  output logic [7:0]  out_draw_x,
  output logic [8:0]  out_draw_y,
  output logic [2:0]  out_glyph_kind,
  output logic        out_glyph_error
);

  tgac_cfg_t    cfg_r;
  tgac_state_t  state_r;
  tgac_state_t  state_nxt;
  tgac_item_t   s1_item_r;
  logic         s1_valid_r;
  logic         out_valid_r;
  tgac_result_t out_result_r;
  tgac_result_t calc_result;
  logic         calc_has_result;
  logic         s1_go;
  logic         out_load;
  logic         cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.font_size_sel <= FONT_SEL_16;
      cfg_r.start_x <= 8'd0;
      cfg_r.start_y <= 9'd0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_FONT_SIZE: cfg_r.font_size_sel <= pwdata[1:0];
        REG_START_X:   cfg_r.start_x <= pwdata[7:0];
        REG_START_Y:   cfg_r.start_y <= pwdata[8:0];
        default:       cfg_r <= cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_FONT_SIZE: prdata = {30'd0, cfg_r.font_size_sel};
      REG_START_X:   prdata = {24'd0, cfg_r.start_x};
      REG_START_Y:   prdata = {23'd0, cfg_r.start_y};
      default:       prdata = 32'd0;
    endcase
  end

  tgac_glyph_calc #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT),
    .GLYPH_GAP    (GLYPH_GAP)
  ) u_calc (
    .item_i      (s1_item_r),
    .state_i     (state_r),
    .cfg_i       (cfg_r),
    .state_o     (state_nxt),
    .has_result_o(calc_has_result),
    .result_o    (calc_result)
  );

  assign s1_go = s1_valid_r && (!calc_has_result || !out_valid_r || out_ready);
  assign out_load = s1_go && calc_has_result;
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_go) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r.text_byte <= in_text_byte;
      s1_item_r.restart <= in_restart;
    end
    if (out_load) begin
      out_result_r <= calc_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_glyph_address = out_result_r.glyph_address;
  assign out_glyph_bytes = out_result_r.glyph_bytes;
  assign out_draw_x = out_result_r.draw_x;
  assign out_draw_y = out_result_r.draw_y;
  assign out_glyph_kind = out_result_r.glyph_kind;
  assign out_glyph_error = out_result_r.glyph_error;

  a_reset_clears_lead: assert property (@(posedge clk)
    !rst_n |=> !state_r.lead_pending && !s1_valid_r && !out_valid_r)
    else $error("lead byte or valid flag survived reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled while a register was free");

  a_good_glyph_has_length: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_result_r.glyph_error |-> out_result_r.glyph_bytes != 7'd0)
    else $error("glyph without error has zero length");

  a_error_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_result_r.glyph_error |->
      (out_result_r.glyph_kind == KIND_A12) || (out_result_r.glyph_kind == KIND_H16) ||
      (out_result_r.glyph_kind == KIND_H24))
    else $error("error word carries an ascii kind other than the default");

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for text_glyph_address_cursor: a scoreboard class predicts
// each glyph word from the accepted text words, and plain tasks drive text and APB writes.
// Depends on tgac_pkg and the RTL of the block only.
module testbench;
  import tgac_pkg::*;

  localparam int SCREEN_W = 240;
  localparam int SCREEN_H = 320;
  localparam int GAP = 1;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_WORDS = 205;

  class glyph_scoreboard;
    localparam int FIRST_CODE = 161;
    localparam int CODES_PER_ROW = 94;
    localparam int SKIPPED_ROWS = 15;

    int glyph_w[5] = '{8, 8, 16, 16, 24};
    int glyph_h[5] = '{12, 16, 24, 16, 24};
    int glyph_len[5] = '{12, 16, 48, 32, 72};
    int glyph_base[5] = '{0, 1536, 5632, 17920, 285536};

    logic [1:0] font_sel = FONT_SEL_16;
    logic [7:0] start_x = '0;
    logic [8:0] start_y = '0;
    logic [7:0] cur_x = '0;
    logic [8:0] cur_y = '0;
    logic [7:0] lead = '0;
    bit lead_held = 0;

    tgac_result_t expected_glyphs[$];
    int mismatches = 0;
    int words_in = 0;
    int glyphs_checked = 0;
    int flagged = 0;

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      unique case (idx)
        REG_FONT_SIZE: font_sel = val[1:0];
        REG_START_X: start_x = val[7:0];
        REG_START_Y: start_y = val[8:0];
        default: ;
      endcase
    endfunction

    function void step_cursor(int w, int h);
      int nx;
      int ny;
      nx = cur_x + w + GAP;
      if (nx >= SCREEN_W) begin
        ny = cur_y + h + GAP;
        nx = 0;
        if (ny >= SCREEN_H) ny = 0;
        cur_y = 9'(ny);
      end
      cur_x = 8'(nx);
    endfunction

    function void note_word(logic [7:0] b, logic rs);
      tgac_result_t e;
      bit hz;
      bit err;
      glyph_kind_t k;
      int row;
      int col;
      int idx;
      int w;
      int h;
      words_in++;
      if (rs) begin
        cur_x = start_x;
        cur_y = start_y;
        lead_held = 0;
        lead = '0;
      end
      if (b == 8'h00) begin
        lead_held = 0;
        return;
      end
      if (!lead_held && b > CODE_BIAS) begin
        lead = b;
        lead_held = 1;
        return;
      end
      hz = lead_held;
      lead_held = 0;
      err = 0;
      k = KIND_A12;
      idx = 0;
      if (font_sel == FONT_SEL_NONE || (hz && font_sel == FONT_SEL_12)) begin
        err = 1;
      end else if (!hz) begin
        k = glyph_kind_t'({1'b0, font_sel});
        idx = int'(b);
      end else begin
        row = int'(lead) - FIRST_CODE;
        col = int'(b) - FIRST_CODE;
        k = (font_sel == FONT_SEL_24) ? KIND_H24 : KIND_H16;
        if (k == KIND_H24) row -= SKIPPED_ROWS;
        idx = CODES_PER_ROW * row + col;
        err = (idx < 0);
      end
      e = '0;
      e.draw_x = cur_x;
      e.draw_y = cur_y;
      e.glyph_error = err;
      // A missing glyph moves the cursor by the gap alone; a bad hanzi index still
      // takes the full cell of its kind.
      if (err && k < KIND_H16) begin
        e.glyph_kind = KIND_A12;
        w = 0;
        h = 0;
      end else begin
        e.glyph_kind = k;
        w = glyph_w[int'(k)];
        h = glyph_h[int'(k)];
        if (!err) begin
          e.glyph_bytes = 7'(glyph_len[int'(k)]);
          e.glyph_address = 20'(glyph_base[int'(k)] + idx * glyph_len[int'(k)]);
        end
      end
      if (err) flagged++;
      step_cursor(w, h);
      expected_glyphs.push_back(e);
    endfunction

    task report_mismatch(string msg);
      if (mismatches < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_glyph(tgac_result_t got);
      tgac_result_t e;
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("unexpected glyph word, address %0d", got.glyph_address));
        return;
      end
      e = expected_glyphs.pop_front();
      glyphs_checked++;
      if (got.glyph_address !== e.glyph_address)
        report_mismatch($sformatf("glyph_address %0d, expected %0d",
                                  got.glyph_address, e.glyph_address));
      if (got.glyph_bytes !== e.glyph_bytes)
        report_mismatch($sformatf("glyph_bytes %0d, expected %0d",
                                  got.glyph_bytes, e.glyph_bytes));
      if (got.draw_x !== e.draw_x)
        report_mismatch($sformatf("draw_x %0d, expected %0d", got.draw_x, e.draw_x));
      if (got.draw_y !== e.draw_y)
        report_mismatch($sformatf("draw_y %0d, expected %0d", got.draw_y, e.draw_y));
      if (got.glyph_kind !== e.glyph_kind)
        report_mismatch($sformatf("glyph_kind %0d, expected %0d",
                                  got.glyph_kind, e.glyph_kind));
      if (got.glyph_error !== e.glyph_error)
        report_mismatch($sformatf("glyph_error %0b, expected %0b",
                                  got.glyph_error, e.glyph_error));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_text_byte = '0;
  logic in_restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [19:0] out_glyph_address;
  logic [6:0] out_glyph_bytes;
  logic [7:0] out_draw_x;
  logic [8:0] out_draw_y;
  logic [2:0] out_glyph_kind;
  logic out_glyph_error;

  glyph_scoreboard sb = new();
  tgac_result_t observed;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int text_words = 0;

  text_glyph_address_cursor #(
    .SCREEN_WIDTH(SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H),
    .GLYPH_GAP(GAP)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_text_byte(in_text_byte),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_glyph_address(out_glyph_address),
    .out_glyph_bytes(out_glyph_bytes),
    .out_draw_x(out_draw_x),
    .out_draw_y(out_draw_y),
    .out_glyph_kind(out_glyph_kind),
    .out_glyph_error(out_glyph_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random, or holds off for a long stretch when asked to.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_asked != hold_seen) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_word(in_text_byte, in_restart);
      if (out_valid && out_ready) begin
        observed.glyph_address = out_glyph_address;
        observed.glyph_bytes = out_glyph_bytes;
        observed.draw_x = out_draw_x;
        observed.draw_y = out_draw_y;
        observed.glyph_kind = glyph_kind_t'(out_glyph_kind);
        observed.glyph_error = out_glyph_error;
        sb.check_glyph(observed);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task cfg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task send_word(logic [7:0] b, logic rs);
    int gap;
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_restart <= rs;
    do @(posedge clk); while (!in_ready);
    text_words++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task drain_and_settle();
    in_valid <= 1'b0;
    while (sb.expected_glyphs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task set_idling(int sender_pct, int receiver_pct);
    send_idle_pct = sender_pct;
    stall_pct <= receiver_pct;
  endtask

  // Mostly well-formed text: ASCII and hanzi pairs, with end-of-string words,
  // restarts and raw bytes that break pairs mixed in.
  task send_random_text();
    int r;
    logic rs;
    logic [7:0] lead_b;
    logic [7:0] trail_b;
    r = $urandom_range(99);
    rs = ($urandom_range(39) == 0);
    if (r < 45) begin
      send_word(8'($urandom_range(1, 160)), rs);
    end else if (r < 80) begin
      if (r < 74) begin
        lead_b = 8'($urandom_range(8'hB0, 8'hF7));
        trail_b = 8'($urandom_range(8'hA1, 8'hFE));
      end else begin
        lead_b = 8'($urandom_range(8'hA1, 8'hFF));
        trail_b = 8'($urandom_range(1, 255));
      end
      send_word(lead_b, rs);
      send_word(trail_b, 1'b0);
    end else if (r < 86) begin
      send_word(8'h00, rs);
    end else begin
      send_word(8'($urandom_range(0, 255)), rs);
    end
  endtask

  logic [1:0] phase_font[6] = '{FONT_SEL_16, FONT_SEL_12, FONT_SEL_24,
                               FONT_SEL_NONE, FONT_SEL_24, FONT_SEL_16};

  initial begin
    int first;
    logic [7:0] sx;
    logic [8:0] sy;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset font size is 16 pixels: ASCII bounds, hanzi bounds, dropped leads, bad trails.
    send_word(8'h41, 1'b1);
    send_word(8'h01, 1'b0);
    send_word(8'hA0, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hB5, 1'b0);
    send_word(8'h41, 1'b1);
    send_word(8'hA1, 1'b0);
    send_word(8'hA0, 1'b0);
    drain_and_settle();

    // At 24 pixels the rows below 0xB0 give a negative index.
    cfg_write(REG_FONT_SIZE, 32'(FONT_SEL_24));
    send_word(8'hA1, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'hAF, 1'b0);
    send_word(8'hFE, 1'b0);
    send_word(8'hB0, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'h7E, 1'b0);
    drain_and_settle();

    cfg_write(REG_FONT_SIZE, 32'(FONT_SEL_12));
    send_word(8'hB0, 1'b0);
    send_word(8'hA1, 1'b0);
    send_word(8'h30, 1'b0);
    drain_and_settle();

    cfg_write(REG_FONT_SIZE, 32'(FONT_SEL_NONE));
    send_word(8'h30, 1'b0);
    send_word(8'hB0, 1'b0);
    send_word(8'hB0, 1'b0);
    drain_and_settle();

    for (int p = 0; p < 6; p++) begin
      unique case (p)
        0: begin sx = 8'd0; sy = 9'd0; end
        1: begin sx = 8'd239; sy = 9'd319; end
        3: begin sx = 8'd255; sy = 9'd511; end
        default: begin
          sx = 8'($urandom_range(0, 239));
          sy = 9'($urandom_range(0, 319));
        end
      endcase
      cfg_write(REG_FONT_SIZE, 32'(phase_font[p]));
      cfg_write(REG_START_X, 32'(sx));
      cfg_write(REG_START_Y, 32'(sy));
      unique case (p % 4)
        0: set_idling(0, 0);
        1: set_idling(74, 0);
        2: set_idling(0, 74);
        default: set_idling(34, 34);
      endcase
      first = text_words;
      send_word(8'($urandom_range(1, 160)), 1'b1);
      while (text_words - first < PHASE_WORDS) send_random_text();
      drain_and_settle();

      if (p == 2) begin
        // The receiver holds off while the sender keeps offering words back to back.
        set_idling(0, 0);
        hold_asked <= hold_asked + 1;
        for (int i = 0; i < 30; i++) send_word(8'($urandom_range(1, 160)), 1'b0);
        drain_and_settle();
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_glyphs.size() != 0)
      sb.report_mismatch($sformatf("%0d expected glyph words never arrived",
                                   sb.expected_glyphs.size()));
    $display("Run covered %0d text words and %0d glyph words (%0d flagged as errors),",
             sb.words_in, sb.glyphs_checked, sb.flagged);
    $display("across all four font selections, off-screen starts and a long output hold-off.");
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/tgac_pkg.sv
rtl/tgac_glyph_calc.sv
rtl/text_glyph_address_cursor.sv
dv/testbench.sv
